// File: sv/sfd_pkg.sv
package sfd_pkg;

	localparam int FRAME_BYTES  = 25;
	localparam int NUM_CHANNELS = 16;
	localparam int STORE_DEPTH  = FRAME_BYTES - 1;
	localparam int CHAN_W       = 11;
	localparam int IDX_W        = 4;
	localparam int POS_W        = 5;
	localparam int PCT_W        = 15;
	localparam int SCALE_W      = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int ACC_W        = 18;
	localparam int NBITS_W      = 5;

	localparam logic [POS_W-1:0]   LAST_STORE_POS = POS_W'(STORE_DEPTH - 1);
	localparam logic [POS_W-1:0]   FLAG_POS       = POS_W'(STORE_DEPTH - 1);
	localparam logic [POS_W-1:0]   HEADER_POS     = '0;
	localparam logic [IDX_W-1:0]   LAST_CHANNEL   = IDX_W'(NUM_CHANNELS - 1);
	localparam logic [CHAN_W-1:0]  CHAN_RESET     = 11'd1000;
	localparam logic [PCT_W-1:0]   PERCENT_FULL   = 15'd25600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER  = 3'd0,
		REG_FOOTER  = 3'd1,
		REG_RMIN    = 3'd2,
		REG_RMAX    = 3'd3,
		REG_SCALE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

endpackage

// File: sv/sbus_frame_decoder_unit.sv
// a non-final byte is stored in the frame memory, with no result
// the frame-ending byte starts a sweep of the 24-entry frame memory, one read a cycle,
// then sixteen beats stream from the held channel memory, one beat a cycle while out_stall is low
// throughput: one byte per cycle between frames; input stalled during sweep and emit
// reset: registers at defaults, position 0, held channels read as 1000 until a good frame
module sbus_frame_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          restart,
	input  logic                          cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    channel_index,
	output logic [10:0]                   chan_raw,
	output logic [14:0]                   percent_q8,
	output logic                          aux_ch17,
	output logic                          aux_ch18,
	output logic                          link_lost,
	output logic                          failsafe,
	output logic                          frame_good,
	output logic                          last
);
	import sfd_pkg::*;

	// config registers
	logic [7:0]         header_q;
	logic [7:0]         footer_q;
	logic [CHAN_W-1:0]  rmin_q;
	logic [CHAN_W-1:0]  rmax_q;
	logic [SCALE_W-1:0] scale_q;

	state_t             state_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   pos_eff;
	logic               in_acc;
	logic               frame_end;

	// frame memory
	logic [7:0]         frame_mem [STORE_DEPTH];
	logic [7:0]         frame_rd_s1;
	logic [POS_W-1:0]   sw_addr_q;
	logic               sw_issue_q;
	logic               rd_valid_s1;
	logic [POS_W-1:0]   rd_addr_s1;

	// unpack
	logic               foot_ok_q;
	logic               ok_q;
	logic [ACC_W-1:0]   acc_q;
	logic [NBITS_W-1:0] nbits_q;
	logic [ACC_W-1:0]   acc_cat;
	logic [NBITS_W-1:0] nb_sum;
	logic               chan_rdy;
	logic [IDX_W-1:0]   ch_cnt_q;
	logic               held_we;
	logic [3:0]         flags_q;

	// held channel memory
	logic [CHAN_W-1:0]  held_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] hvalid_q;
	logic [CHAN_W-1:0]  held_rd_s1;
	logic               hv_s1;
	logic               rd_ok_s1;
	logic [IDX_W-1:0]   emit_idx_q;
	logic [IDX_W-1:0]   held_raddr;
	logic               ld;

	// percent
	logic [CHAN_W-1:0]  cur_val;
	logic [CHAN_W-1:0]  v_lo;
	logic [CHAN_W-1:0]  v_cl;
	logic [CHAN_W-1:0]  dlt;
	logic [CHAN_W+SCALE_W-1:0] prod;
	logic [CHAN_W+SCALE_W:0]   rnd;
	logic [CHAN_W+SCALE_W-16:0] pct_wide;
	logic [PCT_W-1:0]   pct;

	logic               out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign pos_eff   = restart ? '0 : pos_q;
	assign frame_end = (pos_eff > LAST_STORE_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= 8'd15;
			footer_q <= 8'd0;
			rmin_q   <= 11'd192;
			rmax_q   <= 11'd1792;
			scale_q  <= 24'd1048576;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HEADER: header_q <= cfg_data[7:0];
				REG_FOOTER: footer_q <= cfg_data[7:0];
				REG_RMIN:   rmin_q   <= cfg_data[CHAN_W-1:0];
				REG_RMAX:   rmax_q   <= cfg_data[CHAN_W-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// frame memory: write on stored bytes, read during the sweep
	always_ff @(posedge clk) begin
		if (in_acc && !frame_end) begin
			frame_mem[pos_eff] <= data_byte;
		end
		frame_rd_s1 <= frame_mem[sw_addr_q];
	end

	assign acc_cat  = acc_q | (ACC_W'(frame_rd_s1) << nbits_q);
	assign nb_sum   = nbits_q + NBITS_W'(8);
	assign chan_rdy = (nb_sum >= NBITS_W'(CHAN_W));
	assign held_we  = (state_q == ST_SWEEP) && rd_valid_s1 && ok_q &&
		(rd_addr_s1 != HEADER_POS) && (rd_addr_s1 != FLAG_POS) && chan_rdy;

	assign ld = (state_q == ST_EMIT) && rd_ok_s1 && (!out_valid_q || !out_stall);
	assign held_raddr = ld ? emit_idx_q + IDX_W'(1) : emit_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			sw_addr_q   <= '0;
			sw_issue_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_addr_s1  <= '0;
			foot_ok_q   <= 1'b0;
			ok_q        <= 1'b0;
			acc_q       <= '0;
			nbits_q     <= '0;
			ch_cnt_q    <= '0;
			flags_q     <= '0;
			hvalid_q    <= '0;
			rd_ok_s1    <= 1'b0;
			emit_idx_q  <= '0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SWEEP) && sw_issue_q;
			rd_addr_s1  <= sw_addr_q;
			rd_ok_s1    <= (state_q == ST_EMIT) && !(ld && emit_idx_q == LAST_CHANNEL);
			if (held_we) begin
				hvalid_q[ch_cnt_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (frame_end) begin
							pos_q      <= '0;
							state_q    <= ST_SWEEP;
							sw_addr_q  <= '0;
							sw_issue_q <= 1'b1;
							foot_ok_q  <= (data_byte == footer_q);
							acc_q      <= '0;
							nbits_q    <= '0;
							ch_cnt_q   <= '0;
						end else begin
							pos_q <= pos_eff + POS_W'(1);
						end
					end
				end
				ST_SWEEP: begin
					if (sw_issue_q) begin
						if (sw_addr_q == LAST_STORE_POS) begin
							sw_issue_q <= 1'b0;
						end else begin
							sw_addr_q <= sw_addr_q + POS_W'(1);
						end
					end
					if (rd_valid_s1) begin
						if (rd_addr_s1 == HEADER_POS) begin
							ok_q <= foot_ok_q && (frame_rd_s1 == header_q);
						end else if (rd_addr_s1 == FLAG_POS) begin
							if (ok_q) begin
								flags_q <= frame_rd_s1[3:0];
							end
							state_q    <= ST_EMIT;
							emit_idx_q <= '0;
						end else if (chan_rdy) begin
							acc_q    <= acc_cat >> CHAN_W;
							nbits_q  <= nb_sum - NBITS_W'(CHAN_W);
							ch_cnt_q <= ch_cnt_q + IDX_W'(1);
						end else begin
							acc_q   <= acc_cat;
							nbits_q <= nb_sum;
						end
					end
				end
				ST_EMIT: begin
					if (ld) begin
						emit_idx_q <= emit_idx_q + IDX_W'(1);
						if (emit_idx_q == LAST_CHANNEL) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// held channel memory
	always_ff @(posedge clk) begin
		if (held_we) begin
			held_mem[ch_cnt_q] <= acc_cat[CHAN_W-1:0];
		end
		held_rd_s1 <= held_mem[held_raddr];
		hv_s1      <= hvalid_q[held_raddr];
	end

	// clamp and scale
	always_comb begin
		cur_val  = hv_s1 ? held_rd_s1 : CHAN_RESET;
		v_lo     = (cur_val < rmin_q) ? rmin_q : cur_val;
		v_cl     = (v_lo > rmax_q) ? rmax_q : v_lo;
		dlt      = (v_cl >= rmin_q) ? (v_cl - rmin_q) : '0;
		prod     = (CHAN_W+SCALE_W)'(dlt) * (CHAN_W+SCALE_W)'(scale_q);
		rnd      = (CHAN_W+SCALE_W+1)'(prod) + (CHAN_W+SCALE_W+1)'(32768);
		pct_wide = rnd[CHAN_W+SCALE_W:16];
		pct      = (pct_wide > (CHAN_W+SCALE_W-15)'(PERCENT_FULL)) ?
			PERCENT_FULL : pct_wide[PCT_W-1:0];
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			channel_index <= emit_idx_q;
			chan_raw      <= cur_val;
			percent_q8    <= pct;
			aux_ch17      <= flags_q[0];
			aux_ch18      <= flags_q[1];
			link_lost     <= flags_q[2];
			failsafe      <= flags_q[3];
			frame_good    <= ok_q;
			last          <= (emit_idx_q == LAST_CHANNEL);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import sfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int LONG_HOLD      = 300;
	localparam longint FULL_SPAN  = 64'd25600 * 64'd65536;

	typedef struct packed {
		logic [7:0] data;
		logic       rs;
	} rx_byte_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic [10:0] value;
		logic [14:0] pct;
		logic [3:0]  flags;
		logic        fresh;
		logic        last;
	} chan_report_t;

	typedef enum {PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_EDGES} chan_pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic restart = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] channel_index;
	logic [10:0] chan_raw;
	logic [14:0] percent_q8;
	logic aux_ch17, aux_ch18, link_lost, failsafe, frame_good, last;

	sbus_frame_decoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .restart(restart),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.channel_index(channel_index), .chan_raw(chan_raw),
		.percent_q8(percent_q8), .aux_ch17(aux_ch17), .aux_ch18(aux_ch18),
		.link_lost(link_lost), .failsafe(failsafe), .frame_good(frame_good),
		.last(last)
	);

	always #4 clk = ~clk;

	// decoder copy: registers and state
	logic [7:0]  cfg_header = 8'd15;
	logic [7:0]  cfg_footer = 8'd0;
	logic [10:0] cfg_rmin   = 11'd192;
	logic [10:0] cfg_rmax   = 11'd1792;
	logic [23:0] cfg_scale  = 24'd1048576;
	int          dec_pos = 0;
	logic [7:0]  dec_store [STORE_DEPTH];
	logic [10:0] dec_held [NUM_CHANNELS];
	logic [3:0]  dec_flags = '0;

	rx_byte_t     rx_byte_q [$];
	chan_report_t expected_reports [$];

	logic [10:0] edge_vals [16] = '{11'd0, 11'd1, 11'd191, 11'd192, 11'd193, 11'd511,
		11'd1000, 11'd1023, 11'd1024, 11'd1365, 11'd1791, 11'd1792, 11'd1793,
		11'd2000, 11'd2046, 11'd2047};

	int errors = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	bit byte_taken = 1'b0;
	bit aligned = 1'b1;

	function automatic logic [14:0] scale_percent(logic [10:0] v);
		logic [10:0] c;
		logic [10:0] d;
		logic [63:0] p;
		c = v;
		if (c < cfg_rmin) c = cfg_rmin;
		if (c > cfg_rmax) c = cfg_rmax;
		d = (c >= cfg_rmin) ? c - cfg_rmin : '0;
		p = (64'(d) * 64'(cfg_scale) + 64'd32768) >> 16;
		if (p > 64'(PERCENT_FULL)) p = 64'(PERCENT_FULL);
		return p[14:0];
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic rs);
		logic [CHAN_W*NUM_CHANNELS-1:0] bits;
		chan_report_t r;
		logic good;
		if (rs) dec_pos = 0;
		if (dec_pos < STORE_DEPTH) begin
			dec_store[dec_pos] = b;
			dec_pos++;
		end else begin
			dec_pos = 0;
			good = (dec_store[HEADER_POS] == cfg_header) && (b == cfg_footer);
			if (good) begin
				for (int k = 0; k < STORE_DEPTH - 2; k++) bits[8*k +: 8] = dec_store[k+1];
				for (int i = 0; i < NUM_CHANNELS; i++) dec_held[i] = bits[CHAN_W*i +: CHAN_W];
				dec_flags = dec_store[FLAG_POS][3:0];
			end
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				r.idx = i[3:0];
				r.value = dec_held[i];
				r.pct = scale_percent(dec_held[i]);
				r.flags = dec_flags;
				r.fresh = good;
				r.last = (i == NUM_CHANNELS - 1);
				expected_reports.push_back(r);
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic queue_frame(input logic [7:0] hdr, input logic [7:0] ftr,
			input logic [7:0] flagb, input logic rs0, input chan_pattern_t pat);
		logic [CHAN_W*NUM_CHANNELS-1:0] bits;
		logic [10:0] ch;
		rx_byte_t it;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			case (pat)
				PAT_ZERO:  ch = '0;
				PAT_FULL:  ch = '1;
				PAT_EDGES: ch = edge_vals[i];
				default: begin
					ch = 11'($urandom_range(2047));
					if ($urandom_range(7) == 0) ch = $urandom_range(1) ? cfg_rmin : cfg_rmax;
				end
			endcase
			bits[CHAN_W*i +: CHAN_W] = ch;
		end
		it.data = hdr;
		it.rs = rs0;
		rx_byte_q.push_back(it);
		it.rs = 1'b0;
		for (int k = 0; k < STORE_DEPTH - 2; k++) begin
			it.data = bits[8*k +: 8];
			rx_byte_q.push_back(it);
		end
		it.data = flagb;
		rx_byte_q.push_back(it);
		it.data = ftr;
		rx_byte_q.push_back(it);
	endtask

	// random bytes, first one resyncs, occasional restarts inside
	task automatic queue_noise(input int n);
		rx_byte_t it;
		for (int k = 0; k < n; k++) begin
			it.data = 8'($urandom);
			it.rs = (k == 0) || ($urandom_range(9) == 0);
			rx_byte_q.push_back(it);
		end
		aligned = 1'b0;
	endtask

	task automatic random_frames(input int n);
		int r;
		logic [7:0] h, f;
		repeat (n) begin
			r = $urandom_range(99);
			h = cfg_header;
			f = cfg_footer;
			if (r >= 75 && r < 85) h = h ^ 8'($urandom_range(1, 255));
			else if (r >= 85 && r < 92) f = f ^ 8'($urandom_range(1, 255));
			if (r >= 92) begin
				queue_noise($urandom_range(1, 30));
			end else begin
				queue_frame(h, f, 8'($urandom), aligned ? 1'($urandom) : 1'b1, PAT_RANDOM);
				aligned = 1'b1;
			end
		end
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [23:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_HEADER: cfg_header = v[7:0];
			REG_FOOTER: cfg_footer = v[7:0];
			REG_RMIN:   cfg_rmin = v[10:0];
			REG_RMAX:   cfg_rmax = v[10:0];
			REG_SCALE:  cfg_scale = v;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [7:0] h, input logic [7:0] f,
			input logic [10:0] lo, input logic [10:0] hi, input logic [23:0] s);
		write_reg(REG_HEADER, 24'(h));
		write_reg(REG_FOOTER, 24'(f));
		write_reg(REG_RMIN, 24'(lo));
		write_reg(REG_RMAX, 24'(hi));
		write_reg(REG_SCALE, s);
	endtask

	task automatic settle();
		while (rx_byte_q.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int s, input int r);
		send_idle_pct = s;
		recv_stall_pct = r;
	endtask

	// byte driver
	always @(negedge clk) begin
		rx_byte_t nxt;
		if (!in_valid || byte_taken) begin
			if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = rx_byte_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.data;
				restart <= nxt.rs;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		chan_report_t want;
		bit beat_taken;
		if (arst_n) begin
			byte_taken = in_valid && !in_stall;
			beat_taken = out_valid && !out_stall;
			if (byte_taken) decode_byte(data_byte, restart);
			if (beat_taken) begin
				if (expected_reports.size() == 0) begin
					errors++;
					$display("%0t unexpected beat: expected none, actual channel %0d value %0d",
						$time, channel_index, chan_raw);
				end else begin
					want = expected_reports.pop_front();
					check_field("channel_index", want.idx, channel_index);
					check_field("chan_raw", want.value, chan_raw);
					check_field("percent_q8", want.pct, percent_q8);
					check_field("aux_ch17", want.flags[0], aux_ch17);
					check_field("aux_ch18", want.flags[1], aux_ch18);
					check_field("link_lost", want.flags[2], link_lost);
					check_field("failsafe", want.flags[3], failsafe);
					check_field("frame_good", want.fresh, frame_good);
					check_field("last", want.last, last);
				end
			end
			if (byte_taken || beat_taken) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog expired, %0d beats outstanding", $time,
					expected_reports.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [10:0] lo, hi;
		for (int i = 0; i < NUM_CHANNELS; i++) dec_held[i] = CHAN_RESET;
		for (int i = 0; i < STORE_DEPTH; i++) dec_store[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header mismatch from reset, edges, flags, resync, footer mismatch
		set_idle(0, 0);
		queue_frame(8'h0E, cfg_footer, 8'h0F, 1'b1, PAT_EDGES);
		queue_frame(cfg_header, cfg_footer, 8'h0F, 1'b1, PAT_EDGES);
		queue_frame(cfg_header, cfg_footer, 8'hF0, 1'b0, PAT_ZERO);
		queue_noise(10);
		queue_frame(cfg_header, cfg_footer, 8'h05, 1'b1, PAT_FULL);
		queue_frame(cfg_header, 8'hFF, 8'h0A, 1'b0, PAT_RANDOM);
		aligned = 1'b1;
		settle();

		// full range, no idling
		set_all(8'h00, 8'hFF, 11'd0, 11'd2047, 24'(FULL_SPAN / 2047));
		queue_frame(cfg_header, cfg_footer, 8'h03, 1'b1, PAT_EDGES);
		random_frames(1);
		settle();

		// inverted range, largest scale, sender idling
		set_idle(66, 0);
		set_all(8'hFF, 8'h00, 11'd2047, 11'd0, 24'hFFFFFF);
		queue_frame(cfg_header, cfg_footer, 8'h0C, 1'b1, PAT_EDGES);
		random_frames(1);
		settle();

		// empty range, zero scale, receiver stalling
		set_idle(0, 66);
		set_all(8'hA5, 8'h5A, 11'd1000, 11'd1000, 24'h000000);
		random_frames(2);
		settle();

		// saturating scale, long receiver hold-off while bytes keep coming
		set_idle(0, 0);
		set_all(8'h0F, 8'h00, 11'd192, 11'd1792, 24'hFFFFFF);
		hold_req = 1'b1;
		queue_frame(cfg_header, cfg_footer, 8'($urandom), 1'b1, PAT_RANDOM);
		queue_frame(cfg_header, cfg_footer, 8'($urandom), 1'b0, PAT_EDGES);
		aligned = 1'b1;
		settle();

		// random ranges with matching scale
		for (int p = 0; p < 2; p++) begin
			if (p == 0) set_idle(9, 9);
			else set_idle(33, 33);
			lo = 11'($urandom_range(0, 1500));
			hi = 11'($urandom_range(int'(lo) + 101, 2047));
			set_all(8'($urandom), 8'($urandom), lo, hi, 24'(FULL_SPAN / longint'(hi - lo)));
			random_frames(1);
			settle();
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sbus_frame_decoder_unit.f
sv/sfd_pkg.sv
sv/sbus_frame_decoder_unit.sv
verif/tb_top.sv
